### rtl/ngde_pkg.sv
package ngde_pkg;

    // register widths
    localparam int THR_W      = 23;
    localparam int SLOPE_W    = 16;
    localparam int COEF_W     = 24;
    localparam int ENV_W      = 32;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // gain is q1.16, log values carry 16 fraction bits
    localparam int GAIN_W         = 17;
    localparam int LOGF_W         = 16;
    localparam int GAIN_SHIFT_MAX = 16;

    // shared multiplier: signed 33 x 33
    localparam int MUL_W  = 33;
    localparam int PROD_W = 2 * MUL_W;

    // q1.30 working values of the log and exp iterations, q0.30 roots
    localparam int Y_W    = 31;
    localparam int ROOT_W = 30;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 2'd0,
        REG_SLOPE     = 2'd1,
        REG_ATTACK    = 2'd2,
        REG_RELEASE   = 2'd3
    } cfg_reg_t;

    localparam logic [THR_W-1:0]   THR_RESET     = 23'd265271;
    localparam logic [SLOPE_W-1:0] SLOPE_RESET   = 16'd58982;
    localparam logic [COEF_W-1:0]  ATTACK_RESET  = 24'd16739215;
    localparam logic [COEF_W-1:0]  RELEASE_RESET = 24'd16773412;

    localparam logic [GAIN_W-1:0]  UNITY_GAIN    = 17'd65536;

    // integer square root, bit pair at a time
    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned v;
        longint unsigned r;
        longint unsigned b;
        v = x;
        r = 64'd0;
        b = 64'h4000_0000_0000_0000;
        for (int k = 0; k < 32; k++) begin
            if (b > v)
                b = b >> 2;
        end
        for (int k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // q0.30 root 2^(-2^-(t+1)), from repeated square roots of one half
    function automatic logic [ROOT_W-1:0] exp_root(input int t);
        longint unsigned c;
        c = 64'd1 << 29;
        for (int k = 0; k <= t; k++)
            c = int_sqrt(c << 30);
        return ROOT_W'(c);
    endfunction

endpackage

### rtl/noise_gate_downward_expander.sv
// paths: a request whose envelope is zero or at or above the threshold goes straight to the output
// multiply; below the threshold it passes through the two log iterations, the slope multiply and
// the exp iteration, which is skipped when the gain shift passes 16
// throughput: one request in flight; s_tready returns in the cycle the result appears, and no new
// request is taken before then; the two 17-step log iterations on the shared multiplier dominate
// reset: asynchronous, active low; envelope cleared, registers to reset values, no result pending
module noise_gate_downward_expander #(
    parameter int SAMPLE_WIDTH    = 24,
    parameter int TABLE_ADDR_BITS = 8
) (
    input  logic                                     clk,
    input  logic                                     rst_n,

    // configuration write port
    input  logic                                     cfg_we,
    input  logic [ngde_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [ngde_pkg::CFG_DATA_W-1:0]          cfg_data,

    // incoming sample stream
    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in

    // outgoing sample stream
    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]        m_tdata    // [SAMPLE_WIDTH-1:0] sample_out
);

    import ngde_pkg::*;

    localparam int TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int ENV_FRAC = ENV_W - SAMPLE_WIDTH;
    // threshold moved into envelope units can be wider than the envelope
    localparam int THRQ_W   = THR_W + ENV_FRAC;
    localparam int LOG_IN_W = (THRQ_W > ENV_W) ? THRQ_W : ENV_W;
    localparam int POS_W    = $clog2(LOG_IN_W);
    localparam int LOG_W    = POS_W + LOGF_W;
    localparam int B        = TABLE_ADDR_BITS;
    localparam int RI_W     = $clog2(B);
    localparam int LOG_STEPS = LOGF_W;
    localparam int CNT_MAX  = (B > LOG_STEPS) ? B : LOG_STEPS;
    localparam int CNT_W    = $clog2(CNT_MAX + 1);
    localparam int ACC_W    = COEF_W + ENV_W;
    localparam int ESUM_W   = ACC_W + 2;
    localparam int DS_W     = LOG_W + SLOPE_W + 1;

    localparam logic [SAMPLE_WIDTH-2:0] MAG_MAX  = {(SAMPLE_WIDTH-1){1'b1}};
    localparam logic [Y_W-1:0]          ONE_Q30  = Y_W'(1) << 30;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENV_SEL,
        ST_ENV_MUL_A,
        ST_ENV_MUL_B,
        ST_ENV_SUM,
        ST_CHECK,
        ST_LOG_PREP,
        ST_LOG_LOOP,
        ST_SLOPE_MUL,
        ST_EXP_PREP,
        ST_EXP_LOOP,
        ST_OUT_MUL,
        ST_OUT_WAIT
    } state_t;

    // control state
    state_t                    state_reg,    state_next;
    logic                      m_tvalid_reg, m_tvalid_next;
    logic [TDATA_W-1:0]        m_tdata_reg,  m_tdata_next;
    logic [ENV_W-1:0]          env_reg,      env_next;
    logic [CNT_W-1:0]          cnt_reg,      cnt_next;
    logic                      which_reg,    which_next;   // low: threshold log, high: envelope
    logic [THR_W-1:0]          thr_reg,      thr_next;
    logic [SLOPE_W-1:0]        slope_reg,    slope_next;
    logic [COEF_W-1:0]         att_reg,      att_next;
    logic [COEF_W-1:0]         rel_reg,      rel_next;

    // datapath
    logic signed [SAMPLE_WIDTH-1:0] samp_reg, samp_next;
    logic [ENV_W-1:0]          magq_reg,   magq_next;
    logic [COEF_W-1:0]         coef_reg,   coef_next;
    logic [ACC_W-1:0]          acc_reg,    acc_next;
    logic signed [PROD_W-1:0]  prod_reg,   prod_next;
    logic [LOG_IN_W-1:0]       logx_reg,   logx_next;
    logic [POS_W-1:0]          p_reg,      p_next;
    logic [Y_W-1:0]            y_reg,      y_next;
    logic [LOGF_W-1:0]         rlog_reg,   rlog_next;
    logic [LOG_W-1:0]          lt_reg,     lt_next;
    logic [LOG_W-1:0]          d_reg,      d_next;
    logic [POS_W-1:0]          n_reg,      n_next;
    logic [B-1:0]              jsh_reg,    jsh_next;
    logic                      jbit_reg,   jbit_next;
    logic [Y_W-1:0]            rexp_reg,   rexp_next;
    logic [GAIN_W-1:0]         gain_reg,   gain_next;

    // shared multiplier
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic                      mul_en;

    // input magnitude
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [SAMPLE_WIDTH-1:0]   samp_neg;
    logic [SAMPLE_WIDTH-1:0]   samp_abs;
    logic [SAMPLE_WIDTH-2:0]   mag_sat;
    logic [ENV_W-1:0]          magq_in;

    // envelope update
    logic [COEF_W:0]           coef_cmp;
    logic [ESUM_W-1:0]         env_sum;
    logic [LOG_IN_W-1:0]       thrq;
    logic [LOG_IN_W-1:0]       env_ext;

    // log step
    logic [POS_W-1:0]          p_enc;
    logic [POS_W-1:0]          norm_sh;
    logic [LOG_IN_W-1:0]       x_norm;
    logic [Y_W-1:0]            y_start;
    logic                      sq_bit;
    logic [Y_W-1:0]            y_norm;
    logic [Y_W-1:0]            y_cur;
    logic [LOGF_W-1:0]         rlog_step;
    logic [LOG_W-1:0]          log_val;

    // exponent step
    logic [DS_W-1:0]           e_sum;
    logic [LOG_W-1:0]          e_val;
    logic [POS_W-1:0]          e_int;
    logic [B-1:0]              e_idx;
    logic [ROOT_W-1:0]         root_tab [B];
    logic [RI_W-1:0]           root_idx;
    logic [Y_W-1:0]            r_cur;
    logic [ENV_W-1:0]          r_round;
    logic [GAIN_W-1:0]         gain_calc;

    // output rounding
    logic signed [PROD_W-1:0]  out_rnd;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // constant roots of the exp product, one per index bit
    for (genvar g = 0; g < B; g++) begin : g_root
        assign root_tab[g] = exp_root(g);
    end

    assign mul_p = mul_a * mul_b;

    // magnitude of the incoming sample, most negative code saturates
    assign sample_in = $signed(s_tdata[SAMPLE_WIDTH-1:0]);
    assign samp_neg  = -s_tdata[SAMPLE_WIDTH-1:0];
    assign samp_abs  = sample_in[SAMPLE_WIDTH-1] ? samp_neg : s_tdata[SAMPLE_WIDTH-1:0];
    assign mag_sat   = samp_abs[SAMPLE_WIDTH-1] ? MAG_MAX : samp_abs[SAMPLE_WIDTH-2:0];
    assign magq_in   = ENV_W'(mag_sat) << ENV_FRAC;

    // one-pole envelope: a*env + (1-a)*mag, rounded back to q.8
    assign coef_cmp = (COEF_W+1)'(1) << COEF_W;
    assign env_sum  = ESUM_W'(acc_reg) + ESUM_W'(prod_reg[ACC_W:0])
                    + (ESUM_W'(1) << (COEF_W - 1));
    assign thrq     = LOG_IN_W'(thr_reg) << ENV_FRAC;
    assign env_ext  = LOG_IN_W'(env_reg);

    // leading one of the log operand
    always_comb
    begin
        p_enc = '0;
        for (int i = 0; i < LOG_IN_W; i++) begin
            if (logx_reg[i])
                p_enc = POS_W'(i);
        end
    end

    assign norm_sh = POS_W'(LOG_IN_W - 1) - p_enc;
    assign x_norm  = logx_reg << norm_sh;
    // mantissa 1.i in q1.30, index bits taken just below the leading one
    assign y_start = Y_W'(x_norm[LOG_IN_W-1 -: B+1]) << (30 - B);

    // squaring step: a result of two or more halves and yields a one bit
    assign sq_bit    = prod_reg[61];
    assign y_norm    = sq_bit ? prod_reg[61:31] : prod_reg[60:30];
    assign y_cur     = (cnt_reg == '0) ? y_reg : y_norm;
    assign rlog_step = (cnt_reg == '0) ? '0 : {rlog_reg[LOGF_W-2:0], sq_bit};
    assign log_val   = {p_reg, rlog_step};

    // scaled log difference, split into shift and table index
    assign e_sum = DS_W'(prod_reg[LOG_W+SLOPE_W-1:0]) + (DS_W'(1) << (LOGF_W - 1));
    assign e_val = e_sum[LOG_W+LOGF_W-1:LOGF_W];
    assign e_int = e_val[LOG_W-1:LOGF_W];
    assign e_idx = e_val[LOGF_W-1 -: B];

    // product of roots, one bit of the index per step
    assign root_idx  = (cnt_reg == CNT_W'(B)) ? '0 : cnt_reg[RI_W-1:0];
    assign r_cur     = (cnt_reg == '0) ? ONE_Q30 : (jbit_reg ? prod_reg[60:30] : rexp_reg);
    assign r_round   = ENV_W'(r_cur) + ENV_W'(32'd8192);
    assign gain_calc = r_round[30:14] >> n_reg;

    assign out_rnd = prod_reg + PROD_W'(32768);

    always_comb
    begin
        state_next    = state_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        env_next      = env_reg;
        cnt_next      = cnt_reg;
        which_next    = which_reg;
        thr_next      = thr_reg;
        slope_next    = slope_reg;
        att_next      = att_reg;
        rel_next      = rel_reg;

        samp_next  = samp_reg;
        magq_next  = magq_reg;
        coef_next  = coef_reg;
        acc_next   = acc_reg;
        logx_next  = logx_reg;
        p_next     = p_reg;
        y_next     = y_reg;
        rlog_next  = rlog_reg;
        lt_next    = lt_reg;
        d_next     = d_reg;
        n_next     = n_reg;
        jsh_next   = jsh_reg;
        jbit_next  = jbit_reg;
        rexp_next  = rexp_reg;
        gain_next  = gain_reg;

        mul_en = 1'b0;
        mul_a  = '0;
        mul_b  = '0;

        // register writes are for the user to make only while idle; the block does not enforce it
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: thr_next   = cfg_data[THR_W-1:0];
                REG_SLOPE:     slope_next = cfg_data[SLOPE_W-1:0];
                REG_ATTACK:    att_next   = cfg_data[COEF_W-1:0];
                REG_RELEASE:   rel_next   = cfg_data[COEF_W-1:0];
                default:       ;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid) begin
                    samp_next  = sample_in;
                    magq_next  = magq_in;
                    state_next = ST_ENV_SEL;
                end
            end

            // attack weight only while the magnitude is above the envelope
            ST_ENV_SEL:
            begin
                coef_next  = (magq_reg > env_reg) ? att_reg : rel_reg;
                state_next = ST_ENV_MUL_A;
            end

            ST_ENV_MUL_A:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed(MUL_W'(coef_reg));
                mul_b      = $signed(MUL_W'(env_reg));
                state_next = ST_ENV_MUL_B;
            end

            ST_ENV_MUL_B:
            begin
                acc_next   = prod_reg[ACC_W-1:0];
                mul_en     = 1'b1;
                mul_a      = $signed(MUL_W'(coef_cmp - (COEF_W+1)'(coef_reg)));
                mul_b      = $signed(MUL_W'(magq_reg));
                state_next = ST_ENV_SUM;
            end

            ST_ENV_SUM:
            begin
                env_next   = env_sum[ENV_W+COEF_W-1:COEF_W];
                state_next = ST_CHECK;
            end

            // zero envelope shuts the gate, at or above threshold passes unity
            ST_CHECK:
            begin
                if (env_reg == '0) begin
                    gain_next  = '0;
                    state_next = ST_OUT_MUL;
                end else if (env_ext >= thrq) begin
                    gain_next  = UNITY_GAIN;
                    state_next = ST_OUT_MUL;
                end else begin
                    logx_next  = thrq;
                    which_next = 1'b0;
                    state_next = ST_LOG_PREP;
                end
            end

            ST_LOG_PREP:
            begin
                p_next     = p_enc;
                y_next     = y_start;
                cnt_next   = '0;
                state_next = ST_LOG_LOOP;
            end

            // one squaring per cycle, a fraction bit falls out of each
            ST_LOG_LOOP:
            begin
                mul_en    = 1'b1;
                mul_a     = $signed(MUL_W'(y_cur));
                mul_b     = $signed(MUL_W'(y_cur));
                rlog_next = rlog_step;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(LOG_STEPS)) begin
                    cnt_next = '0;
                    if (!which_reg) begin
                        lt_next    = log_val;
                        which_next = 1'b1;
                        logx_next  = env_ext;
                        state_next = ST_LOG_PREP;
                    end else begin
                        d_next     = lt_reg - log_val;
                        state_next = ST_SLOPE_MUL;
                    end
                end
            end

            ST_SLOPE_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = $signed(MUL_W'(d_reg));
                mul_b      = $signed(MUL_W'(slope_reg));
                state_next = ST_EXP_PREP;
            end

            // deep attenuation gives zero gain outright
            ST_EXP_PREP:
            begin
                n_next   = e_int;
                jsh_next = e_idx;
                cnt_next = '0;
                if (e_int > POS_W'(GAIN_SHIFT_MAX)) begin
                    gain_next  = '0;
                    state_next = ST_OUT_MUL;
                end else begin
                    state_next = ST_EXP_LOOP;
                end
            end

            ST_EXP_LOOP:
            begin
                mul_en    = 1'b1;
                mul_a     = $signed(MUL_W'(r_cur));
                mul_b     = $signed(MUL_W'(root_tab[root_idx]));
                rexp_next = r_cur;
                jbit_next = jsh_reg[B-1];
                jsh_next  = jsh_reg << 1;
                cnt_next  = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(B)) begin
                    cnt_next   = '0;
                    gain_next  = gain_calc;
                    state_next = ST_OUT_MUL;
                end
            end

            ST_OUT_MUL:
            begin
                mul_en     = 1'b1;
                mul_a      = MUL_W'(samp_reg);
                mul_b      = $signed(MUL_W'(gain_reg));
                state_next = ST_OUT_WAIT;
            end

            // hold the product until the output register is free
            ST_OUT_WAIT:
            begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next  = TDATA_W'(out_rnd[SAMPLE_WIDTH+15:16]);
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign prod_next = mul_en ? mul_p : prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            env_reg      <= '0;
            cnt_reg      <= '0;
            which_reg    <= 1'b0;
            thr_reg      <= THR_RESET;
            slope_reg    <= SLOPE_RESET;
            att_reg      <= ATTACK_RESET;
            rel_reg      <= RELEASE_RESET;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            env_reg      <= env_next;
            cnt_reg      <= cnt_next;
            which_reg    <= which_next;
            thr_reg      <= thr_next;
            slope_reg    <= slope_next;
            att_reg      <= att_next;
            rel_reg      <= rel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        samp_reg <= samp_next;
        magq_reg <= magq_next;
        coef_reg <= coef_next;
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        logx_reg <= logx_next;
        p_reg    <= p_next;
        y_reg    <= y_next;
        rlog_reg <= rlog_next;
        lt_reg   <= lt_next;
        d_reg    <= d_next;
        n_reg    <= n_next;
        jsh_reg  <= jsh_next;
        jbit_reg <= jbit_next;
        rexp_reg <= rexp_next;
        gain_reg <= gain_next;
    end

endmodule

### rtl/ngde_checker.sv
module ngde_checker #(
    parameter int TDATA_W = 24
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_tvalid,
    input logic               s_tready,
    input logic [TDATA_W-1:0] s_tdata,   // [SAMPLE_WIDTH-1:0] sample_in
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [TDATA_W-1:0] m_tdata    // [SAMPLE_WIDTH-1:0] sample_out
);

    // one request at a time: busy right after a request is taken
    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still ready after a request was taken");

    // a fresh result always comes with the input side free again
    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("result shown while input side still busy");

    // input side only reopens when a result has been produced
    a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(s_tready) |-> m_tvalid)
        else $error("input reopened without a result");

    // stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

endmodule

bind noise_gate_downward_expander ngde_checker #(
    .TDATA_W(TDATA_W)
) u_ngde_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
